/* hdl/ranked_score_table_macros.svh */
// Assertion macros shared by the ranked score table RTL.
// Expects aclk and aresetn in the scope of each use.
`ifndef RANKED_SCORE_TABLE_MACROS_SVH
`define RANKED_SCORE_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSTAB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define RSTAB_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define RSTAB_ASSERT(lbl, prop, msg)
`define RSTAB_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* hdl/rstab_pkg.sv */
// Shared types, constants and compare function of the ranked score table.
// No dependencies; imported by every module of the block.
`default_nettype none
package rstab_pkg;

    localparam int TEAMS      = 256;
    localparam int SCORE_BITS = 48;
    localparam int TEAM_W     = 9;
    localparam int POINTS_W   = 32;
    localparam int TOTAL_W    = 48;
    localparam int IDX_W      = $clog2(TEAMS);
    localparam int SUM_W      = ((SCORE_BITS > POINTS_W) ? SCORE_BITS : POINTS_W) + 1;

    localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

    localparam logic OP_ADD     = 1'b0;
    localparam logic OP_QUERY   = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic                op;
        logic [TEAM_W-1:0]   team;
        logic [POINTS_W-1:0] points;
        logic [TEAM_W-1:0]   rank;
    } in_req_t;

    typedef struct packed {
        logic [TEAM_W-1:0]  ranked_team;
        logic [TOTAL_W-1:0] total_points;
        logic               status;
    } out_res_t;

    typedef struct packed {
        logic [TEAM_W-1:0]     team;
        logic [SCORE_BITS-1:0] total;
    } entry_t;

    typedef struct packed {
        logic load_req;
        logic mem_rd;
        logic sum_load;
        logic row_insert;
        logic scan_start;
        logic row_rotate;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic req_op;
        logic req_bad;
        logic rot_last;
        logic out_free;
    } status_t;

    // a belongs strictly before b: more points, or equal points and lower team
    function automatic logic entry_ahead(input entry_t a, input entry_t b);
        entry_ahead = (a.total > b.total) || ((a.total == b.total) && (a.team < b.team));
    endfunction

endpackage
`default_nettype wire

/* hdl/ranked_score_table.sv */
// Ranked score table: 256 teams kept sorted by total points (ties to the lower
// team number) in a row of cells. An add request runs from acceptance to the next
// acceptance through check, read of the team's total memory, saturating add,
// then one parallel remove/reinsert of the row. A query walks the whole row past
// its head, one cell per cycle, then waits for the result register to drain;
// a bad team or rank goes from the check straight to an error result.
// No clearing pass after reset. team_count is written through cfg_wr_en/cfg_wr_data.
`default_nettype none
module ranked_score_table import rstab_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [TEAM_W-1:0] cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_req_t           s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_res_t               m_data
);

    cmd_t    cmd;
    status_t status;

    rstab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rstab_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
`default_nettype wire

/* hdl/rstab_cell_row.sv */
// Row of sorted (team, total) cells: parallel remove/reinsert and full rotation.
// Depends on rstab_pkg.
`default_nettype none
module rstab_cell_row import rstab_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire cmd_t   cmd,
    input  wire entry_t moved,
    input  wire entry_t old,
    output entry_t      head
);

    entry_t           cell_reg [TEAMS];
    entry_t           cell_next [TEAMS];
    logic [TEAMS-1:0] ahead_new;
    logic [TEAMS-1:0] upto_old;

    always_comb begin
        for (int i = 0; i < TEAMS; i++) begin
            ahead_new[i] = entry_ahead(cell_reg[i], moved);
            upto_old[i]  = entry_ahead(cell_reg[i], old) || (cell_reg[i].team == old.team);
        end
    end

    for (genvar i = 0; i < TEAMS; i++) begin : g_cell
        localparam int NXT = (i + 1) % TEAMS;
        logic prev_ahead;

        if (i == 0) begin : g_first
            assign prev_ahead = 1'b1;
        end else begin : g_rest
            assign prev_ahead = ahead_new[i-1];
        end

        // cells between the new slot and the old slot shift back by one
        always_comb begin
            cell_next[i] = cell_reg[i];
            if (cmd.row_rotate) begin
                cell_next[i] = cell_reg[NXT];
            end else if (cmd.row_insert && !ahead_new[i] && upto_old[i]) begin
                if (prev_ahead) begin
                    cell_next[i] = moved;
                end else begin
                    cell_next[i] = cell_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cell_reg[i].team  <= TEAM_W'(i + 1);
                cell_reg[i].total <= '0;
            end else begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    assign head = cell_reg[0];

endmodule
`default_nettype wire

/* hdl/rstab_datapath.sv */
// Datapath: request register, per-team total memory, saturating adder,
// rank scan counter and the result register. Uses rstab_pkg and rstab_cell_row.
`default_nettype none
`include "ranked_score_table_macros.svh"
module rstab_datapath import rstab_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [TEAM_W-1:0] cfg_wr_data,
    input  wire in_req_t           s_data,
    input  wire cmd_t              cmd,
    output status_t                status,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_res_t               m_data
);

    logic [TEAM_W-1:0]     team_count_reg;
    logic [TEAM_W-1:0]     count_eff;
    in_req_t               req_reg;
    logic [IDX_W-1:0]      team_idx;

    logic [SCORE_BITS-1:0] total_mem [TEAMS];
    logic [TEAMS-1:0]      total_vld_reg;
    logic [SCORE_BITS-1:0] rd_data_reg;
    logic                  rd_vld_reg;
    logic [SCORE_BITS-1:0] old_total;
    logic [SUM_W-1:0]      sum_wide;
    logic [SCORE_BITS-1:0] sum_sat;

    entry_t                moved_reg;
    entry_t                old_reg;
    entry_t                head;

    logic [IDX_W-1:0]      scan_cnt_reg;
    logic [TEAM_W-1:0]     seen_reg;
    logic [TEAM_W-1:0]     seen_next;
    logic                  head_live;
    logic                  hit_reg;
    entry_t                hit_entry_reg;

    logic                  m_valid_reg;
    out_res_t              m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            team_count_reg <= TEAM_W'(256);
        end else if (cfg_wr_en) begin
            team_count_reg <= cfg_wr_data;
        end
    end

    assign count_eff = (team_count_reg > TEAM_W'(TEAMS)) ? TEAM_W'(TEAMS) : team_count_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_data;
        end
    end

    assign team_idx = IDX_W'(req_reg.team - TEAM_W'(1));

    always_comb begin
        status.req_op   = req_reg.op;
        status.rot_last = (scan_cnt_reg == IDX_W'(TEAMS - 1));
        status.out_free = !m_valid_reg || m_ready;
        if (req_reg.op == OP_ADD) begin
            status.req_bad = (req_reg.team == '0) || (req_reg.team > count_eff);
        end else begin
            status.req_bad = (req_reg.rank == '0) || (req_reg.rank > count_eff);
        end
    end

    // per-team totals; entries never written read as zero
    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            rd_data_reg <= total_mem[team_idx];
        end
        if (cmd.sum_load) begin
            total_mem[team_idx] <= sum_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_vld_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end else begin
            if (cmd.mem_rd) begin
                rd_vld_reg <= total_vld_reg[team_idx];
            end
            if (cmd.sum_load) begin
                total_vld_reg[team_idx] <= 1'b1;
            end
        end
    end

    assign old_total = rd_vld_reg ? rd_data_reg : '0;
    assign sum_wide  = SUM_W'(old_total) + SUM_W'(req_reg.points);
    assign sum_sat   = (sum_wide > SUM_W'(SCORE_MAX)) ? SCORE_MAX : sum_wide[SCORE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.sum_load) begin
            moved_reg.team  <= req_reg.team;
            moved_reg.total <= sum_sat;
            old_reg.team    <= req_reg.team;
            old_reg.total   <= old_total;
        end
    end

    rstab_cell_row u_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .moved   (moved_reg),
        .old     (old_reg),
        .head    (head)
    );

    // rank scan: count live teams as they pass the head of the rotating row
    assign head_live = (head.team <= count_eff);
    assign seen_next = seen_reg + TEAM_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
            seen_reg     <= '0;
            hit_reg      <= 1'b0;
        end else begin
            if (cmd.load_req) begin
                hit_reg <= 1'b0;
            end
            if (cmd.scan_start) begin
                scan_cnt_reg <= '0;
                seen_reg     <= '0;
            end else if (cmd.row_rotate) begin
                scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                if (head_live) begin
                    seen_reg <= seen_next;
                    if (!hit_reg && (seen_next == req_reg.rank)) begin
                        hit_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.row_rotate && head_live && !hit_reg && (seen_next == req_reg.rank)) begin
            hit_entry_reg <= head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (hit_reg) begin
                m_data_reg.ranked_team  <= hit_entry_reg.team;
                m_data_reg.total_points <= TOTAL_W'(hit_entry_reg.total);
                m_data_reg.status       <= STATUS_OK;
            end else begin
                m_data_reg.ranked_team  <= '0;
                m_data_reg.total_points <= '0;
                m_data_reg.status       <= STATUS_ERR;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RSTAB_ASSERT_NEVER(a_bad_write, cmd.sum_load && status.req_bad, "total written for bad team")
    `RSTAB_ASSERT(a_hit_rank, hit_reg |-> (seen_reg >= req_reg.rank), "hit before rank reached")

endmodule
`default_nettype wire

/* hdl/rstab_ctrl.sv */
// Controller state machine: sequences check, total update, row insert and rank scan.
// Depends on rstab_pkg; drives the datapath by cmd_t and reads status_t.
`default_nettype none
`include "ranked_score_table_macros.svh"
module rstab_ctrl import rstab_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_SUM    = 3'd2;
    localparam logic [2:0] ST_INSERT = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.req_bad) begin
                    state_next = ST_RESULT;
                end else if (status.req_op == OP_ADD) begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_SUM;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SUM: begin
                cmd.sum_load = 1'b1;
                state_next   = ST_INSERT;
            end
            ST_INSERT: begin
                cmd.row_insert = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_SCAN: begin
                cmd.row_rotate = 1'b1;
                if (status.rot_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `RSTAB_ASSERT_NEVER(a_ins_rot, cmd.row_insert && cmd.row_rotate, "insert during rotation")
    `RSTAB_ASSERT(a_out_free, cmd.out_load |-> status.out_free, "result overwrites pending result")
    `RSTAB_ASSERT(a_accept_chk, (s_valid && s_ready) |=> (state_reg == ST_CHECK), "accept not checked")

endmodule
`default_nettype wire

/* verif/ranked_score_table_test.sv */
// Self-checking testbench for ranked_score_table: a queue-fed driver, a result monitor and a
// standings predictor that mirrors the sorted team table and the team_count register.
// Depends on rstab_pkg and the ranked_score_table RTL only.
`default_nettype none
module ranked_score_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rstab_pkg::*;

    localparam int          SETTLE     = 300;         // longest request is a query, a full row scan
    localparam int          LONG_HOLD  = 1500;
    localparam int          SAT_ADDS   = 24;          // run of max adds piling onto one team
    localparam longint      TIMEOUT_NS = 70_000_000;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [TEAM_W-1:0] cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    in_req_t           s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    out_res_t          m_data;

    ranked_score_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #5 aclk = ~aclk;

    // standings predictor state
    logic [SCORE_BITS-1:0] team_sum [1:TEAMS];
    entry_t                standings [0:TEAMS-1];
    logic [TEAM_W-1:0]     count_reg;

    in_req_t     req_backlog [$];
    out_res_t    expected_ranks [$];
    int unsigned fail_cnt = 0;

    logic        req_taken  = 1'b0;
    out_res_t    predicted;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned hold_kicks = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;
    int unsigned rx_mode    = 0;
    int unsigned mode_left  = 0;
    out_res_t    want;

    function automatic int unsigned live_limit();
        return (count_reg > TEAM_W'(TEAMS)) ? TEAMS : 32'(count_reg);
    endfunction

    function automatic bit outranks(input entry_t a, input entry_t b);
        return (a.total > b.total) || ((a.total == b.total) && (a.team < b.team));
    endfunction

    // Applies one request to the standings; returns 1 when it yields a result.
    function automatic bit standings_apply(input in_req_t r, output out_res_t res);
        int unsigned       lim;
        int unsigned       pos;
        int unsigned       ins;
        int unsigned       seen;
        logic [SCORE_BITS:0] sum;
        entry_t            moved;
        lim = live_limit();
        res.ranked_team  = '0;
        res.total_points = '0;
        res.status       = STATUS_ERR;
        if (r.op == OP_ADD) begin
            if (r.team == 0 || r.team > lim) return 1'b1;
            sum = {1'b0, team_sum[r.team]} + (SCORE_BITS+1)'(r.points);
            if (sum > {1'b0, SCORE_MAX}) sum = {1'b0, SCORE_MAX};
            team_sum[r.team] = sum[SCORE_BITS-1:0];
            pos = 0;
            while (pos < TEAMS && standings[pos].team != r.team) pos++;
            if (pos >= TEAMS) return 1'b0;
            moved.team  = r.team;
            moved.total = sum[SCORE_BITS-1:0];
            // totals only grow, so the team can only climb
            ins = pos;
            while (ins > 0 && outranks(moved, standings[ins-1])) ins--;
            for (int i = pos; i > ins; i--) standings[i] = standings[i-1];
            standings[ins] = moved;
            return 1'b0;
        end
        if (r.rank == 0 || r.rank > lim) return 1'b1;
        seen = 0;
        for (int i = 0; i < TEAMS; i++) begin
            if (standings[i].team <= lim) begin
                seen++;
                if (seen == r.rank) begin
                    res.ranked_team  = standings[i].team;
                    res.total_points = standings[i].total[TOTAL_W-1:0];
                    res.status       = STATUS_OK;
                    return 1'b1;
                end
            end
        end
        return 1'b1;
    endfunction

    // request acceptance and prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                if (standings_apply(s_data, predicted)) expected_ranks.push_back(predicted);
            end
        end
    end

    // driver: bursts of requests with random gaps between them
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (req_backlog.size() != 0) begin
                s_data  <= req_backlog.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                              : $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure, with a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_seen != hold_kicks) begin
            hold_seen <= hold_kicks;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 400);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) != 0);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_ranks.size() == 0) begin
                $display("%0t: unexpected result team %0d total %0d status %0d",
                         $time, m_data.ranked_team, m_data.total_points, m_data.status);
                fail_cnt++;
            end else begin
                want = expected_ranks.pop_front();
                if (m_data.ranked_team !== want.ranked_team) begin
                    $display("%0t: ranked_team expected %0d actual %0d",
                             $time, want.ranked_team, m_data.ranked_team);
                    fail_cnt++;
                end
                if (m_data.total_points !== want.total_points) begin
                    $display("%0t: total_points expected %0d actual %0d",
                             $time, want.total_points, m_data.total_points);
                    fail_cnt++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic push_add(input int unsigned team, input logic [POINTS_W-1:0] pts);
        in_req_t r;
        r.op     = OP_ADD;
        r.team   = TEAM_W'(team);
        r.points = pts;
        r.rank   = TEAM_W'($urandom_range(0, 511));
        req_backlog.push_back(r);
    endtask

    task automatic push_query(input int unsigned rank);
        in_req_t r;
        r.op     = OP_QUERY;
        r.team   = TEAM_W'($urandom_range(0, 511));
        r.points = $urandom;
        r.rank   = TEAM_W'(rank);
        req_backlog.push_back(r);
    endtask

    // mostly in-range requests with mixed point sizes; the rest raw noise
    function automatic in_req_t make_request();
        in_req_t     r;
        int unsigned lim;
        lim      = live_limit();
        r.op     = ($urandom_range(0, 99) < 60) ? OP_ADD : OP_QUERY;
        r.team   = TEAM_W'($urandom_range(0, 511));
        r.rank   = TEAM_W'($urandom_range(0, 511));
        r.points = $urandom;
        if (lim != 0 && $urandom_range(0, 99) < 85) begin
            r.team = TEAM_W'($urandom_range(1, lim));
            r.rank = TEAM_W'($urandom_range(1, lim));
            case ($urandom_range(0, 3))
                0: r.points = $urandom_range(0, 3);      // many equal totals
                1: r.points = $urandom_range(0, 1000);
                2: r.points = $urandom;
                default: r.points = '1;
            endcase
        end
        return r;
    endfunction

    task automatic wait_drained();
        do @(posedge aclk);
        while (req_backlog.size() != 0 || s_valid || expected_ranks.size() != 0);
    endtask

    task automatic set_team_count(input logic [TEAM_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        count_reg = value;
    endtask

    task automatic run_random(input int unsigned n);
        for (int i = 0; i < n; i++) req_backlog.push_back(make_request());
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [TEAM_W-1:0] phase_counts [0:6];
        phase_counts = '{9'd2, 9'd17, 9'd511, 9'd64, 9'd1, 9'd200, 9'd256};
        for (int i = 0; i < TEAMS; i++) begin
            team_sum[i+1]      = '0;
            standings[i].team  = TEAM_W'(i + 1);
            standings[i].total = '0;
        end
        count_reg = 9'd256;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // table as reset, range edges, ties broken by team number
        push_query(1);
        push_query(256);
        push_query(0);
        push_query(511);
        push_add(0, 1);
        push_add(511, 7);
        push_add(256, '1);
        push_add(5, '1);
        push_query(1);
        push_query(2);
        push_add(256, 1);
        push_query(1);

        // teams above the count keep their places but are skipped
        set_team_count(9'd3);
        push_query(1);
        push_query(3);
        push_query(4);
        push_add(4, 9);

        // zero teams: everything is an error
        set_team_count(9'd0);
        push_query(1);
        push_add(1, 1);

        // count above the table size acts as the table size
        set_team_count(9'd511);
        push_query(256);
        push_add(300, 3);

        set_team_count(9'd1);
        push_query(1);
        push_query(2);
        push_add(1, 2);

        for (int p = 0; p < 7; p++) begin
            set_team_count(phase_counts[p]);
            if (p == 3) begin
                // query-heavy backlog while the result side holds off
                for (int i = 0; i < 30; i++) push_query($urandom_range(1, 64));
                hold_kicks++;
                run_random(170);
            end else if (p == 5) begin
                run_random(100);
                wait_drained();
                run_random(100);
            end else begin
                run_random(200);
            end
        end
        set_team_count(TEAM_W'($urandom_range(1, 511)));
        run_random(200);

        // one team pushed well ahead by repeated max adds
        set_team_count(9'd256);
        for (int i = 0; i < SAT_ADDS; i++) push_add(7, '1);
        push_add(7, 5);
        push_query(1);
        push_query(2);

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (fail_cnt == 0 && expected_ranks.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
